@@ rtl/cidwm_pkg.sv @@
// ----------------------------------------------------------------------------
// cidwm_pkg: shared definitions for the CAN identifier window mailbox
// Widths, item kinds, window size and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package cidwm_pkg;

	localparam int IDW     = 11;                // CAN identifier width
	localparam int DATAW   = 64;                // eight payload bytes
	localparam int ENTRIES = 256;               // slots in the window
	localparam int SLOT_W  = $clog2(ENTRIES);   // slot index width

	localparam logic [IDW-1:0] BASE_RST = IDW'(256);

	localparam logic [1:0] KIND_FRAME = 2'd0;
	localparam logic [1:0] KIND_QUERY = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	typedef struct packed {
		logic store;   // write a received frame into its slot
		logic fetch;   // look up a slot for a query
		logic clear;   // drop every valid bit
	} cidwm_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} cidwm_state_t;

endpackage

@@ rtl/cidwm_ram.sv @@
// ----------------------------------------------------------------------------
// cidwm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cidwm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/cidwm_ctrl.sv @@
// ----------------------------------------------------------------------------
// cidwm_ctrl: mailbox controller
// Accepts items, decodes their kind into datapath commands and sequences
// the slot read that a query needs.
// ----------------------------------------------------------------------------
module cidwm_ctrl
	import cidwm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] kind,
	output cidwm_cmd_t cmd,
	output logic       busy,
	output logic       done
);

	cidwm_state_t state_q;
	cidwm_state_t state_d;
	logic         accept;

	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		cmd       = '0;
		cmd.store = accept && (kind == KIND_FRAME);
		cmd.fetch = accept && (kind == KIND_QUERY);
		cmd.clear = accept && (kind == KIND_CLEAR);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.fetch) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				// result beat goes out this cycle
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q == ST_READ);
	assign done = (state_q == ST_READ);

endmodule

@@ rtl/cidwm_dp.sv @@
// ----------------------------------------------------------------------------
// cidwm_dp: mailbox datapath
// Window base register, identifier-to-slot mapping, valid bits and the
// slot payload RAM.
// ----------------------------------------------------------------------------
module cidwm_dp
	import cidwm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cidwm_cmd_t       cmd,
	input  logic [IDW-1:0]   can_ident,
	input  logic [DATAW-1:0] payload,
	input  logic             cfg_we,
	input  logic [IDW-1:0]   cfg_wdata,
	output logic             hit,
	output logic [DATAW-1:0] slot_data
);

	logic [IDW-1:0]     base_id_q;
	logic [ENTRIES-1:0] valid_q;
	logic               hit_s1;
	logic [IDW:0]       off;
	logic               in_window;
	logic [SLOT_W-1:0]  slot;
	logic               wr_en;
	logic [DATAW-1:0]   rd_data;

	// top bit of off is the borrow; with it set off exceeds any window size
	assign off       = {1'b0, can_ident} - {1'b0, base_id_q};
	assign in_window = (off < (IDW+1)'(ENTRIES));
	assign slot      = off[SLOT_W-1:0];
	assign wr_en     = cmd.store && in_window;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_id_q <= BASE_RST;
			valid_q   <= '0;
			hit_s1    <= 1'b0;
		end else begin
			if (cfg_we) begin
				base_id_q <= cfg_wdata;
			end
			if (cmd.clear) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[slot] <= 1'b1;
			end
			if (cmd.fetch) begin
				hit_s1 <= in_window && valid_q[slot];
			end
		end
	end

	cidwm_ram #(
		.WIDTH(DATAW),
		.DEPTH(ENTRIES)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (slot),
		.wdata (payload),
		.re    (cmd.fetch),
		.raddr (slot),
		.rdata (rd_data)
	);

	assign hit       = hit_s1;
	assign slot_data = hit_s1 ? rd_data : '0;

endmodule

@@ rtl/can_id_window_mailbox.sv @@
// ----------------------------------------------------------------------------
// can_id_window_mailbox: CAN receive mailbox for a window of identifiers
// Stores frame payloads per identifier slot and answers slot queries.
// ----------------------------------------------------------------------------
// Usage:
//   An item (kind, can_ident, payload) is taken at a clock edge with start
//   high and busy low. kind selects: received frame, slot query, clear all.
//   A frame whose identifier lies in base_id .. base_id+255 is written to its
//   slot and marks the slot valid; others are dropped. Frame and clear items
//   give no result and leave busy low, so one may follow every cycle.
//   A query reads the slot RAM (registered read) and returns its result
//   beat in the cycle after acceptance: done high for exactly that cycle
//   with hit and slot_data (zero on a miss). busy is high during that cycle,
//   so no new item is taken while the result beat is out.
//   The receiver cannot stall; the result beat is gone after its cycle.
//   The user writes base_id via cfg_we/cfg_wdata only while idle; the block
//   does not enforce it. Stored slots keep their contents and answer for the
//   new window. arst_n clears all valid bits, sets base_id to 256, goes idle.
// ----------------------------------------------------------------------------
module can_id_window_mailbox
	import cidwm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       kind,
	input  logic [IDW-1:0]   can_ident,
	input  logic [DATAW-1:0] payload,
	input  logic             cfg_we,
	input  logic [IDW-1:0]   cfg_wdata,
	output logic             done,
	output logic             hit,
	output logic [DATAW-1:0] slot_data
);

	cidwm_cmd_t cmd;

	cidwm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	cidwm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.can_ident (can_ident),
		.payload   (payload),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.hit       (hit),
		.slot_data (slot_data)
	);

`ifndef SYNTHESIS
	a_query_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == KIND_QUERY) |=> done)
		else $error("query accepted without a result beat");

	a_beat_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.fetch))
		else $error("result beat without a preceding query");

	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat held longer than one cycle");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (slot_data == '0))
		else $error("miss carries nonzero slot data");
`endif

endmodule

@@ verif/mailbox_checker.sv @@
// ----------------------------------------------------------------------------
// mailbox_checker: scoreboard for the CAN identifier window mailbox
// Watches the item, configuration and result channels, keeps its own copy of
// the window base, valid bits and slot bytes, queues the answer each accepted
// query should get and compares every result beat against the oldest one.
// ----------------------------------------------------------------------------
module mailbox_checker
	import cidwm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic [1:0]       kind,
	input  logic [IDW-1:0]   can_ident,
	input  logic [DATAW-1:0] payload,
	input  logic             cfg_we,
	input  logic [IDW-1:0]   cfg_wdata,
	input  logic             done,
	input  logic             hit,
	input  logic [DATAW-1:0] slot_data,
	output int               mismatches,
	output int               outstanding,
	output int               answers,
	output int               hits
);

	typedef struct packed {
		logic             hit;
		logic [DATAW-1:0] data;
	} answer_t;

	answer_t          pending_answers[$];
	logic [IDW-1:0]   window_base;
	logic             slot_valid [ENTRIES];
	logic [DATAW-1:0] slot_bytes [ENTRIES];

	initial begin
		mismatches  = 0;
		outstanding = 0;
		answers     = 0;
		hits        = 0;
	end

	// Map an identifier to its slot; false when it lies outside the window.
	function automatic logic window_slot(input logic [IDW-1:0] ident,
			output logic [SLOT_W-1:0] slot);
		int offset;
		offset = int'(ident) - int'(window_base);
		slot   = offset[SLOT_W-1:0];
		return (offset >= 0) && (offset < ENTRIES);
	endfunction

	task automatic apply_item(input logic [1:0] k, input logic [IDW-1:0] ident,
			input logic [DATAW-1:0] bytes);
		logic [SLOT_W-1:0] slot;
		logic              in_win;
		answer_t           ans;
		in_win = window_slot(ident, slot);
		case (k)
			KIND_FRAME: begin
				if (in_win) begin
					slot_bytes[slot] = bytes;
					slot_valid[slot] = 1'b1;
				end
			end
			KIND_QUERY: begin
				ans.hit  = in_win && slot_valid[slot];
				ans.data = ans.hit ? slot_bytes[slot] : '0;
				pending_answers.push_back(ans);
			end
			KIND_CLEAR: begin
				foreach (slot_valid[i]) slot_valid[i] = 1'b0;
			end
			default: begin
				// unused kind: drop
			end
		endcase
	endtask

	task automatic check_answer();
		answer_t want;
		if (pending_answers.size() == 0) begin
			$error("result beat with no query waiting: hit %0d slot_data %h", hit, slot_data);
			mismatches++;
		end else begin
			want = pending_answers.pop_front();
			answers++;
			if (want.hit) hits++;
			if (hit !== want.hit) begin
				$error("hit: expected %0d, got %0d", want.hit, hit);
				mismatches++;
			end
			if (slot_data !== want.data) begin
				$error("slot_data: expected %h, got %h", want.data, slot_data);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_base = BASE_RST;
			foreach (slot_valid[i]) slot_valid[i] = 1'b0;
			pending_answers.delete();
		end else begin
			// retire the answer first: it belongs to a query taken at an earlier edge
			if (done) check_answer();
			if (cfg_we) window_base = cfg_wdata;
			if (start && !busy) apply_item(kind, can_ident, payload);
		end
		outstanding = pending_answers.size();
	end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for the CAN identifier window mailbox
// Fills every slot, runs directed frames, queries and clears at the window
// extremes, then random phases under several window bases, all but one with
// random item gaps. A separate checker predicts and compares each answer.
// ----------------------------------------------------------------------------
module tb_top;
	import cidwm_pkg::*;

	localparam logic [1:0] KIND_UNUSED    = 2'd3;
	localparam int         ID_MAX         = (1 << IDW) - 1;
	localparam int         BASE_MAX       = 1792;
	localparam int         PHASES         = 8;
	localparam int         PHASE_ITEMS    = 140;
	localparam int         WATCHDOG_LIMIT = 2000;

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	logic             busy;
	logic [1:0]       kind      = '0;
	logic [IDW-1:0]   can_ident = '0;
	logic [DATAW-1:0] payload   = '0;
	logic             cfg_we    = 1'b0;
	logic [IDW-1:0]   cfg_wdata = '0;
	logic             done;
	logic             hit;
	logic [DATAW-1:0] slot_data;

	int mismatches;
	int outstanding;
	int answers;
	int hits;

	int cur_base     = 256;
	int items_sent   = 0;
	int base_changes = 0;
	int idle_cycles  = 0;
	bit gaps_on      = 1'b1;

	can_id_window_mailbox u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.kind      (kind),
		.can_ident (can_ident),
		.payload   (payload),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.hit       (hit),
		.slot_data (slot_data)
	);

	mailbox_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.can_ident   (can_ident),
		.payload     (payload),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.hit         (hit),
		.slot_data   (slot_data),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.answers     (answers),
		.hits        (hits)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d answers outstanding",
				idle_cycles, outstanding);
			$display("status: fail");
			$finish;
		end
	end

	// Present one beat and hold it until the block takes it.
	task automatic drive_item(input logic [1:0] k, input int ident,
			input logic [DATAW-1:0] bytes);
		@(negedge clk);
		while (gaps_on && $urandom_range(0, 99) < 7) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start     <= 1'b1;
		kind      <= k;
		can_ident <= IDW'(ident);
		payload   <= bytes;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	// Drop start and wait until every answer is back and the block is free.
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0 || busy) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic set_window(input int base);
		settle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= IDW'(base);
		@(negedge clk);
		cfg_we   <= 1'b0;
		cur_base = base;
		base_changes++;
	endtask

	function automatic logic [DATAW-1:0] random_bytes();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return '0;
		if (r < 10) return '1;
		return {$urandom, $urandom};
	endfunction

	// One random beat; counted is low when the block would simply ignore it.
	task automatic random_item(output bit counted);
		int         r;
		int         ident;
		logic [1:0] k;
		r = $urandom_range(0, 99);
		if (r < 46) k = KIND_FRAME;
		else if (r < 90) k = KIND_QUERY;
		else if (r < 93) k = KIND_CLEAR;
		else k = KIND_UNUSED;
		r = $urandom_range(0, 99);
		// bias toward a few hot slots so queries find stored frames
		if (r < 50) ident = cur_base + int'($urandom_range(0, 15));
		else if (r < 80) ident = cur_base + int'($urandom_range(0, ENTRIES - 1));
		else if (r < 84) ident = cur_base - 1;
		else if (r < 88) ident = cur_base + ENTRIES;
		else if (r < 90) ident = ID_MAX;
		else ident = int'($urandom_range(0, ID_MAX));
		if (ident < 0 || ident > ID_MAX) ident = int'($urandom_range(0, ID_MAX));
		drive_item(k, ident, random_bytes());
		counted = (k == KIND_QUERY) || (k == KIND_CLEAR) ||
			(k == KIND_FRAME && ident >= cur_base && ident < cur_base + ENTRIES);
	endtask

	initial begin
		int base;
		int done_items;
		bit counted;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// write every slot once under the reset window, then drop the valid bits
		for (int i = 0; i < ENTRIES; i++) drive_item(KIND_FRAME, cur_base + i, random_bytes());
		drive_item(KIND_CLEAR, cur_base, '0);

		drive_item(KIND_QUERY, 256, '0);
		drive_item(KIND_FRAME, 256, '1);
		drive_item(KIND_FRAME, 511, '0);
		drive_item(KIND_FRAME, 300, 64'h0123_4567_89ab_cdef);
		drive_item(KIND_QUERY, 256, '0);
		drive_item(KIND_QUERY, 511, '1);
		drive_item(KIND_QUERY, 255, '0);
		drive_item(KIND_FRAME, 512, 64'hdead_beef_0000_ffff);
		drive_item(KIND_QUERY, 512, '0);
		drive_item(KIND_UNUSED, 300, '1);
		drive_item(KIND_QUERY, 300, '0);
		drive_item(KIND_FRAME, 300, 64'hfedc_ba98_7654_3210);
		drive_item(KIND_QUERY, 300, '0);
		drive_item(KIND_CLEAR, 0, '0);
		drive_item(KIND_QUERY, 256, '0);

		set_window(0);
		drive_item(KIND_FRAME, 0, 64'ha5a5_a5a5_a5a5_a5a5);
		drive_item(KIND_QUERY, 0, '0);
		drive_item(KIND_QUERY, ID_MAX, '0);

		set_window(BASE_MAX);
		drive_item(KIND_FRAME, ID_MAX, '1);
		drive_item(KIND_QUERY, ID_MAX, '0);
		drive_item(KIND_QUERY, BASE_MAX - 1, '0);

		// window cut short at the top identifier; slot 0 still holds the earlier frame
		set_window(ID_MAX);
		drive_item(KIND_QUERY, ID_MAX, '0);
		drive_item(KIND_FRAME, ID_MAX, 64'h5a5a_5a5a_5a5a_5a5a);
		drive_item(KIND_QUERY, ID_MAX, '0);
		drive_item(KIND_QUERY, 0, '0);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: base = 0;
				1: base = BASE_MAX;
				2: base = 1900;
				default: base = int'($urandom_range(0, BASE_MAX));
			endcase
			set_window(base);
			gaps_on    = (p != 3);
			done_items = 0;
			while (done_items < PHASE_ITEMS) begin
				random_item(counted);
				if (counted) done_items++;
			end
		end
		gaps_on = 1'b1;

		settle();
		repeat (4) @(posedge clk);
		$display("covered %0d beats under %0d window bases, top-cut windows included",
			items_sent, base_changes + 1);
		$display("checked %0d query answers: %0d hits, %0d misses",
			answers, hits, answers - hits);
		if (mismatches == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
